/* rtl/stc_pkg.sv */
// shared types and constants for the speed to heat color pipeline
`default_nettype none
package stc_pkg;

    localparam int POS_W = 16;
    localparam int VEL_W = 16;
    localparam int MAG_W = VEL_W;
    localparam int SQ_W = 2 * MAG_W;
    localparam int RAD_W = SQ_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SQRT_REM_W = ROOT_W + 2;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int SPEED_W = ROOT_W;
    localparam int FS_W = 16;
    localparam int COLOR_W = 8;
    localparam int SCALE_W = 9;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam logic [FS_W-1:0] FULL_SCALE_RESET = 16'd5120;
    localparam logic [SCALE_W-1:0] COLOR_SCALE = 9'd510;

    typedef struct packed {
        logic valid;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } side_t;

endpackage
`default_nettype wire

/* rtl/speed_to_heat_color.sv */
// top level: particle speed to blue-green-red heat color pipeline
//
//  channel   signals                                         direction
//  item      start, busy, in_pos_x, in_pos_y, vel_x, vel_y   in
//  result    done, out_pos_x, out_pos_y, red, green, blue    out
//  config    full_scale_speed_we, full_scale_speed           in
//
// one particle per clock; busy is always low, a transfer is start high
// pipeline stages: squares, sum, 16 square root cells, full scale compare,
// one divider cell per fraction bit, color stage
// results show for one cycle on done; the receiver cannot stall
// reset clears the pipeline valid bits and loads full scale 5120 (20.0)
`default_nettype none
module speed_to_heat_color #(
    parameter int RATIO_FRACTION_BITS = stc_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [stc_pkg::POS_W-1:0]     in_pos_x,
    input  wire logic signed [stc_pkg::POS_W-1:0]     in_pos_y,
    input  wire logic signed [stc_pkg::VEL_W-1:0]     vel_x,
    input  wire logic signed [stc_pkg::VEL_W-1:0]     vel_y,
    input  wire logic                                 full_scale_speed_we,
    input  wire logic [stc_pkg::FS_W-1:0]             full_scale_speed,
    output logic                                      done,
    output logic signed [stc_pkg::POS_W-1:0]          out_pos_x,
    output logic signed [stc_pkg::POS_W-1:0]          out_pos_y,
    output logic [stc_pkg::COLOR_W-1:0]               red,
    output logic [stc_pkg::COLOR_W-1:0]               green,
    output logic [stc_pkg::COLOR_W-1:0]               blue
);

    localparam int F = RATIO_FRACTION_BITS;
    localparam int T_W = F + 1;
    localparam int PROD_W = T_W + stc_pkg::SCALE_W;
    localparam int LATENCY = stc_pkg::SQRT_CELLS + F + 4;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << F;
    localparam logic [T_W-1:0] T_HALF = T_W'(1) << (F - 1);

    logic [stc_pkg::FS_W-1:0]      fs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= stc_pkg::FULL_SCALE_RESET;
        end
        else if (full_scale_speed_we)
        begin
            fs_reg <= full_scale_speed;
        end
    end

    // magnitudes and squares
    stc_pkg::side_t                side_in;
    stc_pkg::side_t                sq_side_reg;
    stc_pkg::side_t                sum_side_reg;
    logic [stc_pkg::MAG_W-1:0]     mag_x;
    logic [stc_pkg::MAG_W-1:0]     mag_y;
    logic [stc_pkg::SQ_W-1:0]      sq_x_reg;
    logic [stc_pkg::SQ_W-1:0]      sq_y_reg;
    logic [stc_pkg::SQ_W-1:0]      sum_reg;

    always_comb
    begin
        mag_x = vel_x[stc_pkg::VEL_W-1] ? stc_pkg::MAG_W'(-vel_x) : stc_pkg::MAG_W'(vel_x);
        mag_y = vel_y[stc_pkg::VEL_W-1] ? stc_pkg::MAG_W'(-vel_y) : stc_pkg::MAG_W'(vel_y);
        side_in.valid = start && !busy;
        side_in.pos_x = in_pos_x;
        side_in.pos_y = in_pos_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_side_reg <= '0;
            sum_side_reg <= '0;
        end
        else
        begin
            sq_side_reg <= side_in;
            sum_side_reg <= sq_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg <= stc_pkg::SQ_W'(mag_x) * stc_pkg::SQ_W'(mag_x);
        sq_y_reg <= stc_pkg::SQ_W'(mag_y) * stc_pkg::SQ_W'(mag_y);
        sum_reg <= sq_x_reg + sq_y_reg;
    end

    // square root cells
    stc_pkg::side_t                      sq_side [0:stc_pkg::SQRT_CELLS];
    logic [stc_pkg::RAD_W-1:0]           sq_rad  [0:stc_pkg::SQRT_CELLS];
    logic [stc_pkg::SQRT_REM_W-1:0]      sq_rem  [0:stc_pkg::SQRT_CELLS];
    logic [stc_pkg::ROOT_W-1:0]          sq_root [0:stc_pkg::SQRT_CELLS];

    assign sq_side[0] = sum_side_reg;
    assign sq_rad[0] = sum_reg;
    assign sq_rem[0] = '0;
    assign sq_root[0] = '0;

    for (genvar i = 0; i < stc_pkg::SQRT_CELLS; i++)
    begin : g_sqrt
        stc_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .side_in  (sq_side[i]),
            .rad_in   (sq_rad[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .side_out (sq_side[i+1]),
            .rad_out  (sq_rad[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1])
        );
    end

    // full scale compare
    logic [stc_pkg::SPEED_W-1:0]     speed;
    stc_pkg::side_t                  cmp_side_reg;
    logic                            cmp_sat_reg;
    logic [stc_pkg::FS_W-1:0]        cmp_rem_reg;

    assign speed = sq_root[stc_pkg::SQRT_CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_side_reg <= '0;
        end
        else
        begin
            cmp_side_reg <= sq_side[stc_pkg::SQRT_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_sat_reg <= (fs_reg == '0) || (stc_pkg::FS_W'(speed) >= fs_reg);
        cmp_rem_reg <= stc_pkg::FS_W'(speed);
    end

    // divider cells
    stc_pkg::side_t                  dv_side [0:F];
    logic                            dv_sat  [0:F];
    logic [stc_pkg::FS_W-1:0]        dv_rem  [0:F];
    logic [F-1:0]                    dv_quot [0:F];

    assign dv_side[0] = cmp_side_reg;
    assign dv_sat[0] = cmp_sat_reg;
    assign dv_rem[0] = cmp_rem_reg;
    assign dv_quot[0] = '0;

    for (genvar j = 0; j < F; j++)
    begin : g_div
        stc_div_cell #(
            .FRAC_BITS (F)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .divisor  (fs_reg),
            .side_in  (dv_side[j]),
            .sat_in   (dv_sat[j]),
            .rem_in   (dv_rem[j]),
            .quot_in  (dv_quot[j]),
            .side_out (dv_side[j+1]),
            .sat_out  (dv_sat[j+1]),
            .rem_out  (dv_rem[j+1]),
            .quot_out (dv_quot[j+1])
        );
    end

    // gradient
    logic [T_W-1:0]                  t;
    logic                            low_half;
    logic [T_W-1:0]                  d_up;
    logic [T_W-1:0]                  d_down;
    logic [PROD_W-1:0]               p_up;
    logic [PROD_W-1:0]               p_down;
    logic [stc_pkg::COLOR_W-1:0]     c_up;
    logic [stc_pkg::COLOR_W-1:0]     c_down;
    stc_pkg::side_t                  out_side_reg;
    logic [stc_pkg::COLOR_W-1:0]     red_reg;
    logic [stc_pkg::COLOR_W-1:0]     green_reg;
    logic [stc_pkg::COLOR_W-1:0]     blue_reg;

    always_comb
    begin
        t = dv_sat[F] ? T_ONE : {1'b0, dv_quot[F]};
        low_half = (t <= T_HALF);
        d_up = low_half ? t : (t - T_HALF);
        d_down = low_half ? (T_HALF - t) : (T_ONE - t);
        p_up = PROD_W'(d_up) * PROD_W'(stc_pkg::COLOR_SCALE);
        p_down = PROD_W'(d_down) * PROD_W'(stc_pkg::COLOR_SCALE);
        c_up = p_up[F +: stc_pkg::COLOR_W];
        c_down = p_down[F +: stc_pkg::COLOR_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_side_reg <= '0;
        end
        else
        begin
            out_side_reg <= dv_side[F];
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg <= low_half ? '0 : c_up;
        green_reg <= low_half ? c_up : c_down;
        blue_reg <= low_half ? c_down : '0;
    end

    assign busy = 1'b0;
    assign done = out_side_reg.valid;
    assign out_pos_x = out_side_reg.pos_x;
    assign out_pos_y = out_side_reg.pos_y;
    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;

`ifndef SYNTHESIS
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not come out after pipeline latency");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted item");

    a_red_blue_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(red != '0 && blue != '0))
        else $error("red and blue both lit in one color");
`endif

endmodule
`default_nettype wire

/* rtl/stc_sqrt_cell.sv */
// one digit of the pipelined integer square root
`default_nettype none
module stc_sqrt_cell (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire stc_pkg::side_t                      side_in,
    input  wire logic [stc_pkg::RAD_W-1:0]           rad_in,
    input  wire logic [stc_pkg::SQRT_REM_W-1:0]      rem_in,
    input  wire logic [stc_pkg::ROOT_W-1:0]          root_in,
    output stc_pkg::side_t                           side_out,
    output logic [stc_pkg::RAD_W-1:0]                rad_out,
    output logic [stc_pkg::SQRT_REM_W-1:0]           rem_out,
    output logic [stc_pkg::ROOT_W-1:0]               root_out
);

    localparam int CUR_W = stc_pkg::SQRT_REM_W + 2;

    stc_pkg::side_t                      side_reg;
    logic [stc_pkg::RAD_W-1:0]           rad_reg;
    logic [stc_pkg::SQRT_REM_W-1:0]      rem_reg;
    logic [stc_pkg::ROOT_W-1:0]          root_reg;
    logic [stc_pkg::RAD_W-1:0]           rad_next;
    logic [stc_pkg::SQRT_REM_W-1:0]      rem_next;
    logic [stc_pkg::ROOT_W-1:0]          root_next;
    logic [CUR_W-1:0]                    cur;
    logic [CUR_W-1:0]                    trial;
    logic [CUR_W-1:0]                    diff;
    logic                                ge;

    always_comb
    begin
        cur = {rem_in, rad_in[stc_pkg::RAD_W-1 -: 2]};
        trial = {2'b00, root_in, 2'b01};
        diff = cur - trial;
        ge = (cur >= trial);
        rem_next = ge ? diff[stc_pkg::SQRT_REM_W-1:0] : cur[stc_pkg::SQRT_REM_W-1:0];
        root_next = {root_in[stc_pkg::ROOT_W-2:0], ge};
        rad_next = {rad_in[stc_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
    end

    assign side_out = side_reg;
    assign rad_out = rad_reg;
    assign rem_out = rem_reg;
    assign root_out = root_reg;

endmodule
`default_nettype wire

/* rtl/stc_div_cell.sv */
// one quotient bit of the pipelined restoring divider
`default_nettype none
module stc_div_cell #(
    parameter int FRAC_BITS = stc_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [stc_pkg::FS_W-1:0]      divisor,
    input  wire stc_pkg::side_t                side_in,
    input  wire logic                          sat_in,
    input  wire logic [stc_pkg::FS_W-1:0]      rem_in,
    input  wire logic [FRAC_BITS-1:0]          quot_in,
    output stc_pkg::side_t                     side_out,
    output logic                               sat_out,
    output logic [stc_pkg::FS_W-1:0]           rem_out,
    output logic [FRAC_BITS-1:0]               quot_out
);

    stc_pkg::side_t                  side_reg;
    logic                            sat_reg;
    logic [stc_pkg::FS_W-1:0]        rem_reg;
    logic [FRAC_BITS-1:0]            quot_reg;
    logic [stc_pkg::FS_W-1:0]        rem_next;
    logic [FRAC_BITS-1:0]            quot_next;
    logic [stc_pkg::FS_W:0]          cur;
    logic [stc_pkg::FS_W:0]          diff;
    logic                            ge;

    always_comb
    begin
        cur = {rem_in, 1'b0};
        diff = cur - {1'b0, divisor};
        ge = (cur >= {1'b0, divisor});
        rem_next = ge ? diff[stc_pkg::FS_W-1:0] : cur[stc_pkg::FS_W-1:0];
        quot_next = {quot_in[FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_in;
        rem_reg <= rem_next;
        quot_reg <= quot_next;
    end

    assign side_out = side_reg;
    assign sat_out = sat_reg;
    assign rem_out = rem_reg;
    assign quot_out = quot_reg;

endmodule
`default_nettype wire
